### design/assert_macros.svh
// Assertion macros used by photometric_cost_volume_update.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PCVU_ASSERT(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define PCVU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PCVU_ASSERT(label, clk, rst_n, expr)
`define PCVU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/pcvu_pkg.sv
package pcvu_pkg;

  localparam int COST_W   = 48;
  localparam int WEIGHT_W = 32;
  localparam int CH_W     = 16;
  localparam int SUM_W    = 18;
  localparam int SQ_W     = 32;
  localparam int SQSUM_W  = 34;
  localparam int KEY_W    = 17;
  localparam int QUO_W    = 48;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = 24;

  localparam logic [COST_W-1:0]   COST_RESET   = 48'd196608;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 32'd66;
  localparam logic [WEIGHT_W-1:0] ONE_Q16      = 32'd65536;
  localparam logic [COST_W-1:0]   COST_MAX     = 48'hFFFF_FFFF_FFFF;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX   = 32'hFFFF_FFFF;

  localparam logic [0:0] REG_NORM_MODE      = 1'b0;
  localparam logic [0:0] REG_SINGLE_CHANNEL = 1'b1;

endpackage

### design/photometric_cost_volume_update.sv
// Photometric cost volume update.
// Input channel (in_valid/in_ready) carries one warped sample, its reference
// pixel and a mask for one pixel and depth layer. The result channel
// (out_valid/out_ready) returns the cell's cost and hit weight after the update.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) selects L1 or L2 and
// the single channel option; it is always ready. The user must write it only
// while idle; the block itself does not enforce this. One item enters per cycle
// unless the output stalls, a cell hazard holds it or the memory is being
// cleared. L1 mode uses the 24 stage pipelined divider. A new item for a cell
// that is still in flight waits until the earlier item has left the pipeline
// and written any update to the cost memory. After reset the block sweeps every
// cost memory entry, one per cycle, writing 3.0 and 0.001; in_ready stays low.
// When the receiver stalls, the whole pipeline holds and in_ready falls.
module photometric_cost_volume_update #(
  parameter int PIXEL_COUNT = 4096,
  parameter int LAYER_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_pixel_index,
  input  logic [4:0]  in_layer,
  input  logic        in_valid_mask,
  input  logic [15:0] in_warped_red,
  input  logic [15:0] in_warped_green,
  input  logic [15:0] in_warped_blue,
  input  logic [15:0] in_base_red,
  input  logic [15:0] in_base_green,
  input  logic [15:0] in_base_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] out_cost_value,
  output logic [31:0] out_hit_weight,
  output logic        out_was_updated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [0:0]  cfg_data
);

  localparam int CELLS  = PIXEL_COUNT * LAYER_COUNT;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW = pcvu_pkg::COST_W;
  localparam int WW = pcvu_pkg::WEIGHT_W;
  localparam int KW = pcvu_pkg::KEY_W;
  localparam int NS = pcvu_pkg::DIV_STAGES;

  logic norm_mode_r, single_channel_r, clearing_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic adv, hazard, in_acc;

  assign cfg_ready = 1'b1;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv && !clearing_r && !hazard;
  assign in_acc = in_valid && in_ready;

  // Input decode.
  logic [15:0] dr_in, dg_in, db_in;
  logic [KW-1:0] key_in;
  logic oob_in;
  logic [ADDR_W-1:0] addr_in;
  assign dr_in = (in_warped_red > in_base_red) ? in_warped_red - in_base_red
                                               : in_base_red - in_warped_red;
  assign dg_in = (in_warped_green > in_base_green) ? in_warped_green - in_base_green
                                                   : in_base_green - in_warped_green;
  assign db_in = (in_warped_blue > in_base_blue) ? in_warped_blue - in_base_blue
                                                 : in_base_blue - in_warped_blue;
  assign key_in = {in_pixel_index, in_layer};
  assign oob_in = (32'(in_pixel_index) >= 32'(PIXEL_COUNT)) ||
                  (32'(in_layer) >= 32'(LAYER_COUNT));
  assign addr_in = ADDR_W'(32'(in_pixel_index) * 32'(LAYER_COUNT) + 32'(in_layer));

  // Stage 1.
  logic p1_vld_r, p1_acc_r, p1_mask_r;
  logic [KW-1:0] p1_key_r;
  logic [ADDR_W-1:0] p1_addr_r;
  logic [15:0] p1_dr_r, p1_dg_r, p1_db_r;
  // Stage 2.
  logic p2_vld_r, p2_acc_r, p2_mask_r;
  logic [KW-1:0] p2_key_r;
  logic [pcvu_pkg::SUM_W-1:0] p2_sum_r;
  logic [pcvu_pkg::SQ_W-1:0] p2_sqr_r, p2_sqg_r, p2_sqb_r;
  logic [CW+WW-1:0] ram_rdata;
  // Stage 3.
  logic p3_vld_r, p3_acc_r, p3_mask_r, p3_l2_r, p3_neg_r;
  logic [KW-1:0] p3_key_r;
  logic [CW-1:0] p3_c_r, p3_mag_r;
  logic [WW-1:0] p3_w_r, p3_wnew_r;
  logic [pcvu_pkg::SQSUM_W-1:0] p3_sqsum_r;
  // Divider side line.
  logic d_vld_r [NS];
  logic d_acc_r [NS];
  logic d_upd_r [NS];
  logic d_div_r [NS];
  logic d_neg_r [NS];
  logic [KW-1:0] d_key_r [NS];
  logic [ADDR_W-1:0] d_addr_r [NS];
  logic [CW-1:0] d_base_r [NS];
  logic [WW-1:0] d_w_r [NS];
  logic [ADDR_W-1:0] p2_addr_r, p3_addr_r;
  logic [pcvu_pkg::QUO_W-1:0] quo;

  always_comb begin
    hazard = (p1_vld_r && p1_acc_r && p1_key_r == key_in) ||
             (p2_vld_r && p2_acc_r && p2_key_r == key_in) ||
             (p3_vld_r && p3_acc_r && p3_key_r == key_in);
    for (int k = 0; k < NS; k++) begin
      hazard = hazard || (d_vld_r[k] && d_acc_r[k] && d_key_r[k] == key_in);
    end
  end

  // Stage 2 and 3 arithmetic.
  logic [CW-1:0] c2, s2;
  logic [WW-1:0] w2, wnew2;
  logic [WW:0] winc2;
  assign c2 = ram_rdata[CW+WW-1:WW];
  assign w2 = ram_rdata[WW-1:0];
  assign winc2 = {1'b0, w2} + {1'b0, pcvu_pkg::ONE_Q16};
  assign wnew2 = winc2[WW] ? pcvu_pkg::WEIGHT_MAX : winc2[WW-1:0];
  assign s2 = CW'({p2_sum_r, 8'b0});

  logic [CW:0] l2sum3;
  logic [CW-1:0] l2cost3, base3;
  logic [WW-1:0] wout3;
  assign l2sum3 = {1'b0, p3_c_r} + (CW+1)'(p3_sqsum_r);
  assign l2cost3 = l2sum3[CW] ? pcvu_pkg::COST_MAX : l2sum3[CW-1:0];
  assign base3 = !p3_acc_r ? '0 : ((p3_mask_r && p3_l2_r) ? l2cost3 : p3_c_r);
  assign wout3 = !p3_acc_r ? '0 : (p3_mask_r ? p3_wnew_r : p3_w_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
      for (int k = 0; k < NS; k++) begin
        d_vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      p1_vld_r <= in_acc;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
      d_vld_r[0] <= p3_vld_r;
      for (int k = 1; k < NS; k++) begin
        d_vld_r[k] <= d_vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_acc_r  <= !oob_in;
      p1_mask_r <= in_valid_mask;
      p1_key_r  <= key_in;
      p1_addr_r <= addr_in;
      p1_dr_r   <= dr_in;
      p1_dg_r   <= dg_in;
      p1_db_r   <= db_in;

      p2_acc_r  <= p1_acc_r;
      p2_mask_r <= p1_mask_r;
      p2_key_r  <= p1_key_r;
      p2_addr_r <= p1_addr_r;
      p2_sum_r  <= pcvu_pkg::SUM_W'(p1_dr_r) + pcvu_pkg::SUM_W'(p1_dg_r) +
                   pcvu_pkg::SUM_W'(p1_db_r);
      p2_sqr_r  <= pcvu_pkg::SQ_W'(p1_dr_r) * pcvu_pkg::SQ_W'(p1_dr_r);
      p2_sqg_r  <= single_channel_r ? '0 :
                   pcvu_pkg::SQ_W'(p1_dg_r) * pcvu_pkg::SQ_W'(p1_dg_r);
      p2_sqb_r  <= single_channel_r ? '0 :
                   pcvu_pkg::SQ_W'(p1_db_r) * pcvu_pkg::SQ_W'(p1_db_r);

      p3_acc_r   <= p2_acc_r;
      p3_mask_r  <= p2_mask_r;
      p3_key_r   <= p2_key_r;
      p3_addr_r  <= p2_addr_r;
      p3_l2_r    <= norm_mode_r;
      p3_c_r     <= c2;
      p3_w_r     <= w2;
      p3_wnew_r  <= wnew2;
      p3_sqsum_r <= pcvu_pkg::SQSUM_W'(p2_sqr_r) + pcvu_pkg::SQSUM_W'(p2_sqg_r) +
                    pcvu_pkg::SQSUM_W'(p2_sqb_r);
      p3_neg_r   <= c2 > s2;
      p3_mag_r   <= (c2 > s2) ? c2 - s2 : s2 - c2;

      d_acc_r[0]  <= p3_acc_r;
      d_upd_r[0]  <= p3_acc_r && p3_mask_r;
      d_div_r[0]  <= p3_acc_r && p3_mask_r && !p3_l2_r;
      d_neg_r[0]  <= p3_neg_r;
      d_key_r[0]  <= p3_key_r;
      d_addr_r[0] <= p3_addr_r;
      d_base_r[0] <= base3;
      d_w_r[0]    <= wout3;
      for (int k = 1; k < NS; k++) begin
        d_acc_r[k]  <= d_acc_r[k-1];
        d_upd_r[k]  <= d_upd_r[k-1];
        d_div_r[k]  <= d_div_r[k-1];
        d_neg_r[k]  <= d_neg_r[k-1];
        d_key_r[k]  <= d_key_r[k-1];
        d_addr_r[k] <= d_addr_r[k-1];
        d_base_r[k] <= d_base_r[k-1];
        d_w_r[k]    <= d_w_r[k-1];
      end
    end
  end

  pcvu_div u_div (
    .clk     (clk),
    .en      (adv),
    .rem_in  (WW'(p3_mag_r[CW-1:32])),
    .num_in  ({p3_mag_r[31:0], 16'b0}),
    .den_in  (p3_wnew_r),
    .quo_out (quo)
  );

  // Final update, memory write and output register.
  logic [CW-1:0] cost_fin;
  logic pipe_we, ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CW+WW-1:0] ram_wdata;
  assign cost_fin = !d_div_r[NS-1] ? d_base_r[NS-1] :
                    (d_neg_r[NS-1] ? d_base_r[NS-1] - quo : d_base_r[NS-1] + quo);
  assign pipe_we   = adv && d_vld_r[NS-1] && d_upd_r[NS-1];
  assign ram_we    = clearing_r || pipe_we;
  assign ram_waddr = clearing_r ? clr_addr_r : d_addr_r[NS-1];
  assign ram_wdata = clearing_r ? {pcvu_pkg::COST_RESET, pcvu_pkg::WEIGHT_RESET}
                                : {cost_fin, d_w_r[NS-1]};

  pcvu_ram #(
    .WIDTH (CW + WW),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (adv),
    .raddr (p1_addr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid        <= 1'b0;
      norm_mode_r      <= 1'b0;
      single_channel_r <= 1'b0;
      clearing_r       <= 1'b1;
      clr_addr_r       <= '0;
    end else begin
      if (adv) begin
        out_valid <= d_vld_r[NS-1];
      end
      if (cfg_valid) begin
        case (cfg_index)
          pcvu_pkg::REG_NORM_MODE:      norm_mode_r <= cfg_data[0];
          pcvu_pkg::REG_SINGLE_CHANNEL: single_channel_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (clearing_r) begin
        if (clr_addr_r == ADDR_W'(CELLS - 1)) begin
          clearing_r <= 1'b0;
        end else begin
          clr_addr_r <= clr_addr_r + ADDR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_cost_value  <= cost_fin;
      out_hit_weight  <= d_w_r[NS-1];
      out_was_updated <= d_upd_r[NS-1];
    end
  end

`include "assert_macros.svh"

  `PCVU_ASSERT(a_no_accept_clearing, clk, rst_n, !(in_acc && clearing_r))
  `PCVU_ASSERT(a_no_pipe_write_clearing, clk, rst_n, !(pipe_we && clearing_r))
  `PCVU_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_acc, p1_vld_r)
  `PCVU_ASSERT(a_updated_weight, clk, rst_n,
               !(out_valid && out_was_updated) || out_hit_weight >= pcvu_pkg::ONE_Q16)

endmodule

### design/pcvu_ram.sv
module pcvu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/pcvu_div.sv
// Pipelined restoring divider: quotient = floor(({rem_in, num_in}) / den_in) for rem_in < den_in.
module pcvu_div (
  input  logic                              clk,
  input  logic                              en,
  input  logic [pcvu_pkg::WEIGHT_W-1:0]     rem_in,
  input  logic [pcvu_pkg::QUO_W-1:0]        num_in,
  input  logic [pcvu_pkg::WEIGHT_W-1:0]     den_in,
  output logic [pcvu_pkg::QUO_W-1:0]        quo_out
);

  localparam int NS = pcvu_pkg::DIV_STAGES;
  localparam int RW = pcvu_pkg::WEIGHT_W;
  localparam int QW = pcvu_pkg::QUO_W;

  logic [RW-1:0] rem_r [NS];
  logic [RW-1:0] den_r [NS];
  logic [QW-1:0] num_r [NS];
  logic [QW-1:0] quo_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [RW-1:0] rem_nxt;
    logic [QW-1:0] num_nxt;
    logic [QW-1:0] quo_nxt;
    logic [RW-1:0] den_src;
    logic [RW-1:0] rem_src;
    logic [QW-1:0] num_src;
    logic [QW-1:0] quo_src;

    if (k == 0) begin : g_head
      assign rem_src = rem_in;
      assign num_src = num_in;
      assign quo_src = '0;
      assign den_src = den_in;
    end else begin : g_tail
      assign rem_src = rem_r[k-1];
      assign num_src = num_r[k-1];
      assign quo_src = quo_r[k-1];
      assign den_src = den_r[k-1];
    end

    always_comb begin
      logic [RW:0] trial;
      rem_nxt = rem_src;
      num_nxt = num_src;
      quo_nxt = quo_src;
      for (int s = 0; s < pcvu_pkg::DIV_STEPS; s++) begin
        trial = {rem_nxt, num_nxt[QW-1]};
        num_nxt = {num_nxt[QW-2:0], 1'b0};
        if (trial >= {1'b0, den_src}) begin
          trial = trial - {1'b0, den_src};
          quo_nxt = {quo_nxt[QW-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_nxt[QW-2:0], 1'b0};
        end
        rem_nxt = trial[RW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        num_r[k] <= num_nxt;
        quo_r[k] <= quo_nxt;
        den_r[k] <= den_src;
      end
    end
  end

  assign quo_out = quo_r[NS-1];

endmodule

### tb/sv/cost_volume_checker.sv
`default_nettype none

module cost_volume_checker #(
  parameter int PIXEL_COUNT = 4096,
  parameter int LAYER_COUNT = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [11:0] in_pixel_index,
  input  wire logic [4:0]  in_layer,
  input  wire logic        in_valid_mask,
  input  wire logic [15:0] in_warped_red,
  input  wire logic [15:0] in_warped_green,
  input  wire logic [15:0] in_warped_blue,
  input  wire logic [15:0] in_base_red,
  input  wire logic [15:0] in_base_green,
  input  wire logic [15:0] in_base_blue,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [47:0] out_cost_value,
  input  wire logic [31:0] out_hit_weight,
  input  wire logic        out_was_updated,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [0:0]  cfg_data,
  output int               fail_count,
  output int               pending_count,
  output int               update_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [pcvu_pkg::COST_W-1:0]   cost;
    logic [pcvu_pkg::WEIGHT_W-1:0] weight;
    logic                          updated;
  } cell_result_t;

  logic [pcvu_pkg::COST_W-1:0]   cost_cells [int unsigned];
  logic [pcvu_pkg::WEIGHT_W-1:0] weight_cells [int unsigned];
  cell_result_t        expected_cells [$];
  logic                l2_mode;
  logic                red_only;

  function automatic logic [63:0] chan_diff(logic [15:0] a, logic [15:0] b);
    return (a > b) ? 64'(a - b) : 64'(b - a);
  endfunction

  function automatic logic [pcvu_pkg::WEIGHT_W-1:0] bump_weight(
      logic [pcvu_pkg::WEIGHT_W-1:0] w);
    logic [32:0] h;
    h = {1'b0, w} + 33'(pcvu_pkg::ONE_Q16);
    return h[32] ? pcvu_pkg::WEIGHT_MAX : h[31:0];
  endfunction

  function automatic logic [63:0] mean_step(logic [63:0] mag, logic [63:0] h);
    logic [63:0] q;
    logic [63:0] r;
    q = mag / h;
    r = mag % h;
    return (q << 16) + ((r << 16) / h);
  endfunction

  function automatic cell_result_t update_cell();
    cell_result_t res;
    int unsigned  addr;
    logic [63:0]  c;
    logic [63:0]  s;
    logic [63:0]  dr;
    logic [63:0]  dg;
    logic [63:0]  db;
    logic [pcvu_pkg::WEIGHT_W-1:0] w;
    res = '0;
    if (in_pixel_index >= PIXEL_COUNT || in_layer >= LAYER_COUNT) return res;
    addr = in_pixel_index * LAYER_COUNT + in_layer;
    c = cost_cells.exists(addr) ? 64'(cost_cells[addr]) : 64'(pcvu_pkg::COST_RESET);
    w = weight_cells.exists(addr) ? weight_cells[addr] : pcvu_pkg::WEIGHT_RESET;
    dr = chan_diff(in_warped_red, in_base_red);
    dg = chan_diff(in_warped_green, in_base_green);
    db = chan_diff(in_warped_blue, in_base_blue);
    if (in_valid_mask) begin
      if (!l2_mode) begin
        s = (dr + dg + db) << 8;
        w = bump_weight(w);
        if (s >= c) c = c + mean_step(s - c, 64'(w));
        else c = c - mean_step(c - s, 64'(w));
      end else begin
        s = dr * dr;
        if (!red_only) s = s + dg * dg + db * db;
        c = (s > 64'(pcvu_pkg::COST_MAX) - c) ? 64'(pcvu_pkg::COST_MAX) : c + s;
        w = bump_weight(w);
      end
      cost_cells[addr] = c[pcvu_pkg::COST_W-1:0];
      weight_cells[addr] = w;
    end
    res.cost = c[pcvu_pkg::COST_W-1:0];
    res.weight = w;
    res.updated = in_valid_mask;
    return res;
  endfunction

  always @(posedge clk) begin
    cell_result_t want;
    if (!rst_n) begin
      l2_mode = 1'b0;
      red_only = 1'b0;
      fail_count <= 0;
      update_count <= 0;
      expected_cells.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pcvu_pkg::REG_NORM_MODE) l2_mode = cfg_data[0];
        else if (cfg_index == pcvu_pkg::REG_SINGLE_CHANNEL) red_only = cfg_data[0];
      end
      if (in_valid && in_ready) expected_cells.push_back(update_cell());
      if (out_valid && out_ready) begin
        update_count <= update_count + 1;
        if (expected_cells.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_cells.pop_front();
          if (out_cost_value !== want.cost) begin
            $error("cost_value expected %0h got %0h", want.cost, out_cost_value);
            fail_count <= fail_count + 1;
          end else if (out_hit_weight !== want.weight) begin
            $error("hit_weight expected %0h got %0h", want.weight, out_hit_weight);
            fail_count <= fail_count + 1;
          end else if (out_was_updated !== want.updated) begin
            $error("was_updated expected %0b got %0b", want.updated, out_was_updated);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_count <= expected_cells.size();
  end

endmodule

`default_nettype wire

### tb/sv/tb_photometric_cost_volume_update.sv
`default_nettype none

module tb_photometric_cost_volume_update;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int PHASE_ITEMS = 190;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [11:0] in_pixel_index = '0;
  logic [4:0]  in_layer = '0;
  logic        in_valid_mask = 1'b0;
  logic [15:0] in_warped_red = '0;
  logic [15:0] in_warped_green = '0;
  logic [15:0] in_warped_blue = '0;
  logic [15:0] in_base_red = '0;
  logic [15:0] in_base_green = '0;
  logic [15:0] in_base_blue = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [47:0] out_cost_value;
  logic [31:0] out_hit_weight;
  logic        out_was_updated;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [0:0]  cfg_data = '0;
  int          fail_count;
  int          pending_count;
  int          update_count;
  int          cycle_count = 0;
  int          items_sent = 0;
  int          settings_used = 0;
  logic        long_hold = 1'b0;

  always #2 clk = ~clk;

  photometric_cost_volume_update DUT (.*);

  cost_volume_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int span;
    int pick;
    int k;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        for (k = 0; k < 400; k++) @(posedge clk);
        long_hold <= 1'b0;
      end
      span = $urandom_range(20, 150);
      pick = $urandom_range(0, 3);
      for (k = 0; k < span && !long_hold; k++) begin
        case (pick)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((k % 8) < 5);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [0:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic select_norm(logic l2, logic red);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    write_reg(pcvu_pkg::REG_NORM_MODE, l2);
    write_reg(pcvu_pkg::REG_SINGLE_CHANNEL, red);
    settings_used++;
  endtask

  task automatic send_sample(logic [11:0] pix, logic [4:0] lay, logic mask,
                             logic [15:0] wr, logic [15:0] wg, logic [15:0] wb,
                             logic [15:0] br, logic [15:0] bg, logic [15:0] bb);
    in_valid <= 1'b1;
    in_pixel_index <= pix;
    in_layer <= lay;
    in_valid_mask <= mask;
    in_warped_red <= wr;
    in_warped_green <= wg;
    in_warped_blue <= wb;
    in_base_red <= br;
    in_base_green <= bg;
    in_base_blue <= bb;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  function automatic logic [15:0] pick_channel();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_run(int count);
    int burst;
    int n;
    logic [11:0] pix;
    logic [4:0] lay;
    n = 0;
    while (n < count) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && n < count) begin
        if ($urandom_range(0, 1) == 0) begin
          pix = 12'($urandom_range(0, 7)) | ($urandom_range(0, 1) ? 12'hFF8 : 12'h000);
          lay = 5'($urandom_range(0, 3)) | ($urandom_range(0, 1) ? 5'h1C : 5'h00);
        end else begin
          pix = 12'($urandom);
          lay = 5'($urandom);
        end
        send_sample(pix, lay, $urandom_range(0, 6) != 0, pick_channel(), pick_channel(),
                    pick_channel(), pick_channel(), pick_channel(), pick_channel());
        burst--;
        n++;
      end
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int k;
    repeat (4) @(posedge clk);
    select_norm(1'b0, 1'b0);
    send_sample(12'd0, 5'd0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 16'h0);
    send_sample(12'd0, 5'd0, 1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_sample(12'd0, 5'd0, 1'b0, 16'h1234, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_sample(12'hFFF, 5'd31, 1'b1, 16'h0, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(12'hFFF, 5'd31, 1'b1, 16'h0300, 16'h0300, 16'h0300, 16'h0, 16'h0, 16'h0);
    send_sample(12'hFFF, 5'd0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_sample(12'd0, 5'd31, 1'b1, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0100);
    for (k = 0; k < 6; k++)
      send_sample(12'd5, 5'd7, 1'b1, 16'(k * 16'h0800), 16'h0040, 16'hFFFF,
                  16'h0, 16'h0041, 16'h0);
    in_valid <= 1'b0;
    select_norm(1'b1, 1'b0);
    send_sample(12'd1, 5'd1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 16'h0);
    send_sample(12'd1, 5'd1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 16'h0);
    send_sample(12'd1, 5'd1, 1'b0, 16'h0, 16'h0, 16'h0, 16'hFFFF, 16'h0, 16'h0);
    send_sample(12'd0, 5'd0, 1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    in_valid <= 1'b0;
    select_norm(1'b1, 1'b1);
    send_sample(12'd1, 5'd1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 16'h0);
    send_sample(12'hFFF, 5'd31, 1'b1, 16'h0, 16'h1, 16'h1, 16'h0, 16'h0, 16'h0);
    in_valid <= 1'b0;
    select_norm(1'b0, 1'b1);
    long_hold <= 1'b1;
    random_run(PHASE_ITEMS);
    select_norm(1'b1, 1'b0);
    random_run(PHASE_ITEMS);
    select_norm(1'b1, 1'b1);
    random_run(PHASE_ITEMS);
    select_norm(1'b0, 1'b0);
    random_run(PHASE_ITEMS);
    select_norm(1'b1, 1'b0);
    random_run(PHASE_ITEMS);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d samples and checked %0d cell updates over %0d register settings.",
             items_sent, update_count, settings_used);
    if (fail_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
